// ----- hdl/pcsr_pkg.sv -----
// Shared types and constants for the PCIe configuration space register block.
package pcsr_pkg;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_ADD_CAP = 3'd2,
        OP_UPD_CAP = 3'd3,
        OP_ADD_EXT = 3'd4,
        OP_INIT    = 3'd5,
        OP_RSVD6   = 3'd6,
        OP_RSVD7   = 3'd7
    } op_t;

    localparam logic [2:0] CFG_SIZE_MODE   = 3'd0;
    localparam logic [2:0] CFG_VENDOR      = 3'd1;
    localparam logic [2:0] CFG_DEVICE      = 3'd2;
    localparam logic [2:0] CFG_REVISION    = 3'd3;
    localparam logic [2:0] CFG_HEADER_KIND = 3'd4;
    localparam logic [2:0] CFG_PM_EV_EN    = 3'd5;
    localparam logic [2:0] CFG_LINK_EV_EN  = 3'd6;

    localparam logic [31:0] RD_UNIMPL     = 32'hFFFF_FFFF;
    localparam logic [31:0] LOW_BYTE_KEEP = 32'hFFFF_FF00;
    localparam logic [15:0] CAP_PTR_OFF   = 16'h0034;
    localparam logic [15:0] EXT_BASE_OFF  = 16'h0100;
    localparam logic [7:0]  PM_CAP_ID     = 8'h01;
    localparam logic [7:0]  PCIE_CAP_ID   = 8'h10;
    localparam logic [15:0] PMCSR_DELTA   = 16'h0004;
    localparam logic [15:0] LNKCTL_DELTA  = 16'h0010;
    localparam logic [31:0] CAP_LIST_BIT  = 32'h0010_0000;

    typedef struct packed {
        logic [15:0] ctl;
        logic [7:0]  nxt;
        logic [7:0]  off;
        logic [7:0]  id;
    } std_entry_t;

    typedef enum logic [1:0] {
        SCAN_DUP_STD,
        SCAN_DUP_EXT,
        SCAN_EVENTS
    } scan_kind_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_IDLE,
        ST_DECODE,
        ST_RD_DATA,
        ST_SCAN,
        ST_CHECK,
        ST_ADD_STD,
        ST_P34_RD,
        ST_P34_WR,
        ST_UPD_DATA,
        ST_ADD_EXT,
        ST_WR,
        ST_POST,
        ST_X_WR,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/pcsr_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module pcsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          q
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q <= mem[raddr];
    end
endmodule

// ----- hdl/pcie_config_space_regs_unit.sv -----
// PCIe type 0 configuration space: dword store plus standard and extended capability lists.
// One beat is handled at a time. A read passes decode, a read of the dword store and the result
// beat; a plain write passes decode, the store write and the post state. When an event enable is
// set and the standard list is not empty the write also scans that list, one step per standard
// capability. An add first searches its list for a duplicate, one step per entry already in it,
// then stores the entry (the first standard entry also patches the dword at 0x34 before the
// write) and then goes through the write path; the first extended entry, when it
// patches the dword at 0x100, does so after the write. Each scan step is one read of the
// capability table followed by one compare. Init sweeps the whole dword store and then loads
// three header dwords. After reset the block runs the same sweep with in_stall high;
// configuration writes are taken meanwhile.
module pcie_config_space_regs_unit #(
    parameter int SPACE_WORDS  = 1024,
    parameter int MAX_STD_CAPS = 16,
    parameter int MAX_EXT_CAPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [15:0] byte_offset,
    input  logic [31:0] write_data,
    input  logic [15:0] cap_ident,
    input  logic [15:0] cap_link,
    input  logic [15:0] cap_control,
    input  logic [4:0]  cap_slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        ok,
    output logic        pm_event,
    output logic [1:0]  pm_state,
    output logic        link_event,
    output logic [1:0]  aspm_state
);
    import pcsr_pkg::*;

    localparam int AW  = $clog2(SPACE_WORDS);
    localparam int SAW = (MAX_STD_CAPS > 1) ? $clog2(MAX_STD_CAPS) : 1;
    localparam int EAW = (MAX_EXT_CAPS > 1) ? $clog2(MAX_EXT_CAPS) : 1;
    localparam int SCW = $clog2(MAX_STD_CAPS + 1);
    localparam int ECW = $clog2(MAX_EXT_CAPS + 1);
    localparam int IW  = (SCW > ECW) ? SCW : ECW;
    localparam int MAXB = SPACE_WORDS * 4;
    localparam logic [16:0] BYTES_SMALL = 17'((MAXB < 256) ? MAXB : 256);
    localparam logic [16:0] BYTES_LARGE = 17'((MAXB < 4096) ? MAXB : 4096);
    localparam logic [AW-1:0] CAP_PTR_WORD  = AW'(13);
    localparam logic [AW-1:0] EXT_BASE_WORD = AW'(64);
    localparam logic [AW-1:0] LAST_WORD     = AW'(SPACE_WORDS - 1);

    function automatic logic valid_off(input logic [15:0] o, input logic [16:0] sb);
        return (o[1:0] == 2'b00) && ({1'b0, o} < sb);
    endfunction

    // configuration
    logic        size_mode_reg, pm_en_reg, link_en_reg;
    logic [15:0] vendor_reg, device_reg;
    logic [7:0]  rev_reg, hkind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_mode_reg <= 1'b1;
            vendor_reg    <= '0;
            device_reg    <= '0;
            rev_reg       <= '0;
            hkind_reg     <= '0;
            pm_en_reg     <= 1'b0;
            link_en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_MODE:   size_mode_reg <= cfg_data[0];
                CFG_VENDOR:      vendor_reg    <= cfg_data;
                CFG_DEVICE:      device_reg    <= cfg_data;
                CFG_REVISION:    rev_reg       <= cfg_data[7:0];
                CFG_HEADER_KIND: hkind_reg     <= cfg_data[7:0];
                CFG_PM_EV_EN:    pm_en_reg     <= cfg_data[0];
                CFG_LINK_EV_EN:  link_en_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    logic [16:0] space_bytes;
    assign space_bytes = size_mode_reg ? BYTES_LARGE : BYTES_SMALL;

    // memories
    logic            sp_we;
    logic [AW-1:0]   sp_waddr, sp_raddr;
    logic [31:0]     sp_wdata, sp_q;
    logic            st_we;
    logic [SAW-1:0]  st_waddr, st_raddr;
    std_entry_t      st_wdata, st_q;
    logic            ex_we;
    logic [EAW-1:0]  ex_waddr, ex_raddr;
    logic [15:0]     ex_wdata, ex_q;

    pcsr_ram #(.WIDTH(32), .DEPTH(SPACE_WORDS)) u_space (
        .clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
        .raddr(sp_raddr), .q(sp_q)
    );

    pcsr_ram #(.WIDTH($bits(std_entry_t)), .DEPTH(MAX_STD_CAPS)) u_std_caps (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .q(st_q)
    );

    pcsr_ram #(.WIDTH(16), .DEPTH(MAX_EXT_CAPS)) u_ext_caps (
        .clk(clk), .we(ex_we), .waddr(ex_waddr), .wdata(ex_wdata),
        .raddr(ex_raddr), .q(ex_q)
    );

    // sequencer state
    state_t      state_reg, state_next;
    scan_kind_t  kind_reg, kind_next;
    logic [AW-1:0]  sweep_reg, sweep_next;
    logic [IW-1:0]  scan_reg, scan_next;
    logic [SCW-1:0] std_cnt_reg, std_cnt_next;
    logic [ECW-1:0] ext_cnt_reg, ext_cnt_next;
    logic [15:0] wr_off_reg, wr_off_next;
    logic [31:0] wr_val_reg, wr_val_next;
    logic        post_x_reg, post_x_next;
    logic        init_reg, init_next;
    logic        pm_done_reg, pm_done_next, link_done_reg, link_done_next;
    logic [1:0]  last_pm_reg, last_pm_next, last_aspm_reg, last_aspm_next;
    logic [31:0] rd_reg, rd_next;
    logic        ok_reg, ok_next, pm_ev_reg, pm_ev_next, link_ev_reg, link_ev_next;
    logic        out_valid_reg, out_valid_next;

    // latched beat
    op_t         op_reg;
    logic [15:0] off_reg, id_reg, link_reg, ctl_reg;
    logic [31:0] data_reg;
    logic [4:0]  slot_reg;

    logic accept;
    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(op);
            off_reg  <= byte_offset;
            data_reg <= write_data;
            id_reg   <= cap_ident;
            link_reg <= cap_link;
            ctl_reg  <= cap_control;
            slot_reg <= cap_slot;
        end
    end

    logic [IW-1:0] scan_limit;
    std_entry_t    new_std, upd_std;
    logic [16:0]   pm_addr, lnk_addr;

    always_comb
    begin
        scan_limit = (kind_reg == SCAN_DUP_EXT) ? IW'(ext_cnt_reg) : IW'(std_cnt_reg);
        new_std.ctl = ctl_reg;
        new_std.nxt = link_reg[7:0];
        new_std.off = off_reg[7:0];
        new_std.id  = id_reg[7:0];
        upd_std     = st_q;
        upd_std.ctl = ctl_reg;
        pm_addr  = {9'd0, st_q.off} + {1'b0, PMCSR_DELTA};
        lnk_addr = {9'd0, st_q.off} + {1'b0, LNKCTL_DELTA};

        state_next     = state_reg;
        kind_next      = kind_reg;
        sweep_next     = sweep_reg;
        scan_next      = scan_reg;
        std_cnt_next   = std_cnt_reg;
        ext_cnt_next   = ext_cnt_reg;
        wr_off_next    = wr_off_reg;
        wr_val_next    = wr_val_reg;
        post_x_next    = post_x_reg;
        init_next      = init_reg;
        pm_done_next   = pm_done_reg;
        link_done_next = link_done_reg;
        last_pm_next   = last_pm_reg;
        last_aspm_next = last_aspm_reg;
        rd_next        = rd_reg;
        ok_next        = ok_reg;
        pm_ev_next     = pm_ev_reg;
        link_ev_next   = link_ev_reg;
        out_valid_next = out_valid_reg && out_stall;

        sp_we    = 1'b0;
        sp_waddr = wr_off_reg[AW+1:2];
        sp_wdata = wr_val_reg;
        sp_raddr = off_reg[AW+1:2];
        st_we    = 1'b0;
        st_waddr = SAW'(std_cnt_reg);
        st_wdata = new_std;
        st_raddr = scan_reg[SAW-1:0];
        ex_we    = 1'b0;
        ex_waddr = EAW'(ext_cnt_reg);
        ex_wdata = off_reg;
        ex_raddr = scan_reg[EAW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                sp_we      = 1'b1;
                sp_waddr   = sweep_reg;
                sp_wdata   = '0;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_WORD)
                begin
                    state_next = init_reg ? ST_HDR0 : ST_IDLE;
                end
            end
            ST_HDR0:
            begin
                sp_we      = 1'b1;
                sp_waddr   = AW'(0);
                sp_wdata   = {device_reg, vendor_reg};
                state_next = ST_HDR1;
            end
            ST_HDR1:
            begin
                sp_we      = 1'b1;
                sp_waddr   = AW'(1);
                sp_wdata   = CAP_LIST_BIT;
                state_next = ST_HDR2;
            end
            ST_HDR2:
            begin
                sp_we      = 1'b1;
                sp_waddr   = AW'(2);
                sp_wdata   = {hkind_reg, 16'd0, rev_reg};
                state_next = ST_DONE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                rd_next      = '0;
                ok_next      = 1'b0;
                pm_ev_next   = 1'b0;
                link_ev_next = 1'b0;
                post_x_next  = 1'b0;
                scan_next    = '0;
                state_next   = ST_DONE;
                unique case (op_reg)
                    OP_READ:
                    begin
                        if (valid_off(off_reg, space_bytes))
                        begin
                            state_next = ST_RD_DATA;
                        end
                        else
                        begin
                            rd_next = RD_UNIMPL;
                        end
                    end
                    OP_WRITE:
                    begin
                        wr_off_next = off_reg;
                        wr_val_next = data_reg;
                        state_next  = ST_WR;
                    end
                    OP_ADD_CAP:
                    begin
                        if (valid_off({8'd0, off_reg[7:0]}, space_bytes) &&
                            !(link_reg[7:0] != 8'd0 &&
                              {9'd0, link_reg[7:0]} >= space_bytes))
                        begin
                            kind_next  = SCAN_DUP_STD;
                            state_next = ST_SCAN;
                        end
                    end
                    OP_UPD_CAP:
                    begin
                        st_raddr = SAW'(slot_reg);
                        if (32'(slot_reg) < 32'(std_cnt_reg))
                        begin
                            state_next = ST_UPD_DATA;
                        end
                    end
                    OP_ADD_EXT:
                    begin
                        if (valid_off(off_reg, space_bytes) &&
                            !(link_reg != 16'd0 && {1'b0, link_reg} >= space_bytes))
                        begin
                            kind_next  = SCAN_DUP_EXT;
                            state_next = ST_SCAN;
                        end
                    end
                    OP_INIT:
                    begin
                        std_cnt_next = '0;
                        init_next    = 1'b1;
                        sweep_next   = '0;
                        state_next   = ST_CLEAR;
                    end
                    default: ;
                endcase
            end
            ST_RD_DATA:
            begin
                rd_next    = sp_q;
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_reg == scan_limit)
                begin
                    unique case (kind_reg)
                        SCAN_DUP_STD: state_next = ST_ADD_STD;
                        SCAN_DUP_EXT: state_next = ST_ADD_EXT;
                        default:      state_next = ST_POST;
                    endcase
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                scan_next  = scan_reg + IW'(1);
                state_next = ST_SCAN;
                unique case (kind_reg)
                    SCAN_DUP_STD:
                    begin
                        if (st_q.off == off_reg[7:0])
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    SCAN_DUP_EXT:
                    begin
                        if (ex_q == off_reg)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        // first matching entry of each kind decides
                        if (pm_en_reg && !pm_done_reg && st_q.id == PM_CAP_ID &&
                            {1'b0, wr_off_reg} == pm_addr)
                        begin
                            pm_done_next = 1'b1;
                            if (wr_val_reg[1:0] != last_pm_reg)
                            begin
                                last_pm_next = wr_val_reg[1:0];
                                pm_ev_next   = 1'b1;
                            end
                        end
                        if (link_en_reg && !link_done_reg && st_q.id == PCIE_CAP_ID &&
                            {1'b0, wr_off_reg} == lnk_addr)
                        begin
                            link_done_next = 1'b1;
                            if (wr_val_reg[1:0] != last_aspm_reg)
                            begin
                                last_aspm_next = wr_val_reg[1:0];
                                link_ev_next   = 1'b1;
                            end
                        end
                    end
                endcase
            end
            ST_ADD_STD:
            begin
                if (32'(std_cnt_reg) >= 32'(MAX_STD_CAPS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    st_we        = 1'b1;
                    std_cnt_next = std_cnt_reg + SCW'(1);
                    ok_next      = 1'b1;
                    wr_off_next  = {8'd0, off_reg[7:0]};
                    wr_val_next  = {ctl_reg, link_reg[7:0], id_reg[7:0]};
                    state_next   = (std_cnt_reg == '0) ? ST_P34_RD : ST_WR;
                end
            end
            ST_P34_RD:
            begin
                sp_raddr   = CAP_PTR_WORD;
                state_next = ST_P34_WR;
            end
            ST_P34_WR:
            begin
                sp_we      = 1'b1;
                sp_waddr   = CAP_PTR_WORD;
                sp_wdata   = (sp_q & LOW_BYTE_KEEP) | {24'd0, off_reg[7:0]};
                state_next = ST_WR;
            end
            ST_UPD_DATA:
            begin
                st_we       = 1'b1;
                st_waddr    = SAW'(slot_reg);
                st_wdata    = upd_std;
                ok_next     = 1'b1;
                wr_off_next = {8'd0, st_q.off};
                wr_val_next = {ctl_reg, st_q.nxt, st_q.id};
                state_next  = ST_WR;
            end
            ST_ADD_EXT:
            begin
                if (32'(ext_cnt_reg) >= 32'(MAX_EXT_CAPS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ex_we        = 1'b1;
                    ext_cnt_next = ext_cnt_reg + ECW'(1);
                    ok_next      = 1'b1;
                    wr_off_next  = off_reg;
                    wr_val_next  = {link_reg[11:0], 4'd0, id_reg};
                    post_x_next  = (ext_cnt_reg == '0) && (off_reg != EXT_BASE_OFF) &&
                                   ({1'b0, EXT_BASE_OFF} < space_bytes);
                    state_next   = ST_WR;
                end
            end
            ST_WR:
            begin
                state_next = ST_POST;
                if (valid_off(wr_off_reg, space_bytes) && wr_off_reg != 16'd0 &&
                    wr_off_reg != CAP_PTR_OFF)
                begin
                    sp_we = 1'b1;
                    if ((pm_en_reg || link_en_reg) && std_cnt_reg != '0)
                    begin
                        kind_next      = SCAN_EVENTS;
                        scan_next      = '0;
                        pm_done_next   = 1'b0;
                        link_done_next = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_POST:
            begin
                sp_raddr   = EXT_BASE_WORD;
                state_next = post_x_reg ? ST_X_WR : ST_DONE;
            end
            ST_X_WR:
            begin
                sp_we      = 1'b1;
                sp_waddr   = EXT_BASE_WORD;
                sp_wdata   = (sp_q & LOW_BYTE_KEEP) | {24'd0, off_reg[7:0]};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                init_next      = 1'b0;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            kind_reg      <= SCAN_DUP_STD;
            sweep_reg     <= '0;
            scan_reg      <= '0;
            std_cnt_reg   <= '0;
            ext_cnt_reg   <= '0;
            wr_off_reg    <= '0;
            wr_val_reg    <= '0;
            post_x_reg    <= 1'b0;
            init_reg      <= 1'b0;
            pm_done_reg   <= 1'b0;
            link_done_reg <= 1'b0;
            last_pm_reg   <= '0;
            last_aspm_reg <= '0;
            rd_reg        <= '0;
            ok_reg        <= 1'b0;
            pm_ev_reg     <= 1'b0;
            link_ev_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            sweep_reg     <= sweep_next;
            scan_reg      <= scan_next;
            std_cnt_reg   <= std_cnt_next;
            ext_cnt_reg   <= ext_cnt_next;
            wr_off_reg    <= wr_off_next;
            wr_val_reg    <= wr_val_next;
            post_x_reg    <= post_x_next;
            init_reg      <= init_next;
            pm_done_reg   <= pm_done_next;
            link_done_reg <= link_done_next;
            last_pm_reg   <= last_pm_next;
            last_aspm_reg <= last_aspm_next;
            rd_reg        <= rd_next;
            ok_reg        <= ok_next;
            pm_ev_reg     <= pm_ev_next;
            link_ev_reg   <= link_ev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = rd_reg;
    assign ok         = ok_reg;
    assign pm_event   = pm_ev_reg;
    assign pm_state   = last_pm_reg;
    assign link_event = link_ev_reg;
    assign aspm_state = last_aspm_reg;

    a_std_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(std_cnt_reg) <= 32'(MAX_STD_CAPS))
        else $error("standard capability count past limit");

    a_ok_only_on_list_ops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ok_reg |->
            op_reg == OP_ADD_CAP || op_reg == OP_UPD_CAP || op_reg == OP_ADD_EXT)
        else $error("ok raised on an op that cannot succeed");

    a_rdata_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rd_reg != 32'd0 |-> op_reg == OP_READ)
        else $error("read data nonzero on a non-read beat");

    a_pm_event_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && pm_ev_reg |-> pm_en_reg)
        else $error("power event while disabled");

endmodule

// ----- tb/sv/tb_pcie_config_space_regs_unit.sv -----
// Self-checking testbench for the PCIe configuration space register block.
module tb_pcie_config_space_regs_unit;
    import pcsr_pkg::*;

    typedef struct {
        op_t         op;
        logic [15:0] off;
        logic [31:0] data;
        logic [15:0] id;
        logic [15:0] lnk;
        logic [15:0] ctl;
        logic [4:0]  slot;
    } beat_t;

    typedef struct {
        logic [31:0] rd;
        logic        ok;
        logic        pe;
        logic [1:0]  ps;
        logic        le;
        logic [1:0]  as;
    } resp_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  op = '0;
    logic [15:0] byte_offset = '0;
    logic [31:0] write_data = '0;
    logic [15:0] cap_ident = '0;
    logic [15:0] cap_link = '0;
    logic [15:0] cap_control = '0;
    logic [4:0]  cap_slot = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [31:0] read_data;
    logic        ok;
    logic        pm_event;
    logic [1:0]  pm_state;
    logic        link_event;
    logic [1:0]  aspm_state;

    pcie_config_space_regs_unit DUT (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] mem [1024];
    logic [7:0]  s_id [16];
    logic [7:0]  s_off [16];
    logic [7:0]  s_nxt [16];
    logic [15:0] s_ctl [16];
    int          n_std = 0;
    logic [15:0] x_off [16];
    int          n_ext = 0;
    logic [1:0]  pwr = 0, aspm = 0;
    logic        ev_pm, ev_ln;
    logic        sz_mode = 1, pm_en = 0, ln_en = 0;
    logic [15:0] ven = 0, dev = 0;
    logic [7:0]  rev = 0, hk = 0;

    beat_t pend [$];
    resp_t expected_resp [$];
    beat_t cur;
    int    errors = 0;
    int    gap = 0;
    int    hold = 0;
    bit    calm = 0;

    initial foreach (mem[i]) mem[i] = '0;

    function automatic int span();
        return sz_mode ? 4096 : 256;
    endfunction

    function automatic bit fits(logic [15:0] o);
        return o[1:0] == 2'b00 && int'(o) < span();
    endfunction

    function automatic void store_word(logic [15:0] o, logic [31:0] v);
        if (!fits(o) || o == 16'h0000 || o == CAP_PTR_OFF)
            return;
        mem[o[11:2]] = v;
        if (pm_en)
            for (int i = 0; i < n_std; i++)
                if (s_id[i] == PM_CAP_ID && o == 16'(s_off[i]) + PMCSR_DELTA) begin
                    if (v[1:0] != pwr) begin
                        pwr = v[1:0];
                        ev_pm = 1;
                    end
                    break;
                end
        if (ln_en)
            for (int i = 0; i < n_std; i++)
                if (s_id[i] == PCIE_CAP_ID && o == 16'(s_off[i]) + LNKCTL_DELTA) begin
                    if (v[1:0] != aspm) begin
                        aspm = v[1:0];
                        ev_ln = 1;
                    end
                    break;
                end
    endfunction

    function automatic bit add_std(beat_t b);
        logic [7:0] o8;
        o8 = b.off[7:0];
        if (!fits(16'(o8)))
            return 0;
        if (b.lnk[7:0] != 0 && int'(b.lnk[7:0]) >= span())
            return 0;
        for (int i = 0; i < n_std; i++)
            if (s_off[i] == o8)
                return 0;
        if (n_std >= 16)
            return 0;
        s_id[n_std] = b.id[7:0];
        s_off[n_std] = o8;
        s_nxt[n_std] = b.lnk[7:0];
        s_ctl[n_std] = b.ctl;
        n_std++;
        if (n_std == 1)
            mem[13] = (mem[13] & LOW_BYTE_KEEP) | 32'(o8);
        store_word(16'(o8), {b.ctl, b.lnk[7:0], b.id[7:0]});
        return 1;
    endfunction

    function automatic bit add_ext(beat_t b);
        if (!fits(b.off))
            return 0;
        if (b.lnk != 0 && int'(b.lnk) >= span())
            return 0;
        for (int i = 0; i < n_ext; i++)
            if (x_off[i] == b.off)
                return 0;
        if (n_ext >= 16)
            return 0;
        x_off[n_ext] = b.off;
        n_ext++;
        store_word(b.off, {16'h0, b.id} | {b.lnk[11:0], 20'h0});
        if (n_ext == 1 && b.off != EXT_BASE_OFF && int'(EXT_BASE_OFF) < span())
            mem[64] = (mem[64] & LOW_BYTE_KEEP) | 32'(b.off[7:0]);
        return 1;
    endfunction

    // work out the response of one accepted beat and queue it
    function automatic void apply_beat(beat_t b);
        resp_t r;
        r = '{default: '0};
        ev_pm = 0;
        ev_ln = 0;
        case (b.op)
            OP_READ:    r.rd = fits(b.off) ? mem[b.off[11:2]] : RD_UNIMPL;
            OP_WRITE:   store_word(b.off, b.data);
            OP_ADD_CAP: r.ok = add_std(b);
            OP_UPD_CAP:
                if (int'(b.slot) < n_std) begin
                    s_ctl[b.slot] = b.ctl;
                    store_word(16'(s_off[b.slot]), {b.ctl, s_nxt[b.slot], s_id[b.slot]});
                    r.ok = 1;
                end
            OP_ADD_EXT: r.ok = add_ext(b);
            OP_INIT:
                begin
                    foreach (mem[i]) mem[i] = '0;
                    n_std = 0;
                    mem[0] = {dev, ven};
                    mem[2] = {hk, 16'h0, rev};
                    mem[1] = CAP_LIST_BIT;
                end
            default: ;
        endcase
        r.pe = ev_pm;
        r.ps = pwr;
        r.le = ev_ln;
        r.as = aspm;
        expected_resp = {expected_resp, r};
    endfunction

    function automatic beat_t rnd_beat();
        beat_t b;
        b.op = op_t'($urandom_range(0, 7));
        b.off = 16'($urandom);
        b.data = $urandom;
        b.id = 16'($urandom);
        b.lnk = 16'($urandom);
        b.ctl = 16'($urandom);
        b.slot = 5'($urandom);
        return b;
    endfunction

    function automatic void push_beat(op_t o, logic [15:0] off, logic [31:0] d,
                                      logic [15:0] id, logic [15:0] lnk,
                                      logic [15:0] ctl, logic [4:0] slot);
        beat_t b;
        b = '{o, off, d, id, lnk, ctl, slot};
        pend = {pend, b};
    endfunction

    // init, a PM and a PCIe capability plus up to 17 others, then traffic aimed at them
    function automatic void push_session(int adds);
        beat_t b;
        logic [15:0] pm_o, px_o, t;
        int r;
        pm_o = 16'($urandom_range(16, 40) * 4);
        px_o = pm_o + 16'h0020;
        push_beat(OP_INIT, 16'($urandom), $urandom, 0, 0, 0, 0);
        push_beat(OP_ADD_CAP, pm_o, $urandom, 16'h0001, 16'($urandom_range(0, 255)),
                  16'($urandom), 0);
        push_beat(OP_ADD_CAP, px_o, $urandom, 16'h0010, 0, 16'($urandom), 0);
        for (int i = 0; i < adds; i++) begin
            b = rnd_beat();
            b.op = OP_ADD_CAP;
            b.off = 16'($urandom_range(0, 255)) & (($urandom_range(0, 5) == 0) ? 16'hFF : 16'hFC);
            pend = {pend, b};
        end
        for (int i = 0; i < 15; i++) begin
            b = rnd_beat();
            r = $urandom_range(0, 99);
            t = $urandom_range(0, 1) ? pm_o + PMCSR_DELTA : px_o + LNKCTL_DELTA;
            if (r < 40) begin
                b.op = OP_WRITE;
                b.off = t;
            end else if (r < 55) begin
                b.op = OP_UPD_CAP;
                b.slot = 5'($urandom_range(0, adds + 2));
            end else if (r < 65) begin
                b.op = OP_ADD_EXT;
                b.off = 16'($urandom_range(0, 1023) * 4);
                if ($urandom_range(0, 3) == 0)
                    b.lnk = 16'($urandom_range(0, 4095));
            end else if (r < 85) begin
                b.op = OP_READ;
                b.off = $urandom_range(0, 1) ? t : 16'($urandom_range(0, 1023) * 4);
            end
            pend = {pend, b};
        end
    endfunction

    task automatic set_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SIZE_MODE:   sz_mode = val[0];
            CFG_VENDOR:      ven = val;
            CFG_DEVICE:      dev = val;
            CFG_REVISION:    rev = val[7:0];
            CFG_HEADER_KIND: hk = val[7:0];
            CFG_PM_EV_EN:    pm_en = val[0];
            CFG_LINK_EV_EN:  ln_en = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic wait_idle();
        while (pend.size() != 0 || expected_resp.size() != 0 || in_valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_all(logic sm, logic [15:0] v, logic [15:0] d, logic [7:0] rv,
                           logic [7:0] h, logic pe, logic le);
        set_reg(CFG_SIZE_MODE, 16'(sm));
        set_reg(CFG_VENDOR, v);
        set_reg(CFG_DEVICE, d);
        set_reg(CFG_REVISION, 16'(rv));
        set_reg(CFG_HEADER_KIND, 16'(h));
        set_reg(CFG_PM_EV_EN, 16'(pe));
        set_reg(CFG_LINK_EV_EN, 16'(le));
    endtask

    task automatic run_random(int n);
        int adds;
        while (n > 0) begin
            if ($urandom_range(0, 9) < 7) begin
                adds = ($urandom_range(0, 10) == 0) ? 17 : $urandom_range(0, 4);
                push_session(adds);
                n -= 18 + adds;
            end else begin
                pend = {pend, rnd_beat()};
                n--;
            end
        end
    endtask

    // driver: beats taken from pend, prediction made at acceptance
    always @(posedge clk or negedge rst_n) begin
        bit go;
        if (!rst_n) begin
            in_valid <= 0;
        end else begin
            if (in_valid && !in_stall)
                apply_beat(cur);
            if (!in_valid || !in_stall) begin
                go = 0;
                if (gap > 0)
                    gap--;
                else if (pend.size() > 0) begin
                    cur = pend.pop_front();
                    go = 1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        gap = $urandom_range(1, 8);
                end
                in_valid <= go;
                if (go) begin
                    op <= cur.op;
                    byte_offset <= cur.off;
                    write_data <= cur.data;
                    cap_ident <= cur.id;
                    cap_link <= cur.lnk;
                    cap_control <= cur.ctl;
                    cap_slot <= cur.slot;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            errors++;
        end
    endfunction

    // monitor: compares each result beat with the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        resp_t e;
        if (!rst_n) begin
            out_stall <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_resp.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = expected_resp.pop_front();
                    check_field("read_data", e.rd, read_data);
                    check_field("ok", 32'(e.ok), 32'(ok));
                    check_field("pm_event", 32'(e.pe), 32'(pm_event));
                    check_field("pm_state", 32'(e.ps), 32'(pm_state));
                    check_field("link_event", 32'(e.le), 32'(link_event));
                    check_field("aspm_state", 32'(e.as), 32'(aspm_state));
                end
            end
            if (hold > 0) begin
                hold--;
                out_stall <= 1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(0, 7);
                out_stall <= 1;
            end else begin
                out_stall <= 0;
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        set_all(1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1, 1);
        push_beat(OP_INIT, 0, 0, 0, 0, 0, 0);
        push_beat(OP_READ, 16'h0000, 0, 0, 0, 0, 0);
        push_beat(OP_READ, 16'hFFFF, 0, 0, 0, 0, 0);
        push_beat(OP_READ, 16'h0003, 0, 0, 0, 0, 0);
        push_beat(OP_WRITE, 16'h0000, '1, 0, 0, 0, 0);
        push_beat(OP_WRITE, 16'h0034, '1, 0, 0, 0, 0);
        push_beat(OP_WRITE, 16'h0FFC, '1, 0, 0, 0, 0);
        push_beat(OP_READ, 16'h0FFC, 0, 0, 0, 0, 0);
        push_beat(OP_WRITE, 16'h1002, '1, 0, 0, 0, 0);
        push_beat(OP_ADD_CAP, 16'h0041, 0, 16'h0001, 0, 0, 0);
        push_beat(OP_ADD_CAP, 16'h0040, 0, 16'hFF01, 16'hFF50, 16'hFFFF, 0);
        push_beat(OP_ADD_CAP, 16'h0040, 0, 16'h0010, 0, 0, 0);
        push_beat(OP_ADD_CAP, 16'h0050, 0, 16'h0010, 16'h00FF, 16'h0000, 0);
        push_beat(OP_WRITE, 16'h0044, 32'h3, 0, 0, 0, 0);
        push_beat(OP_WRITE, 16'h0044, 32'h3, 0, 0, 0, 0);
        push_beat(OP_WRITE, 16'h0060, 32'h2, 0, 0, 0, 0);
        push_beat(OP_UPD_CAP, 0, 0, 0, 0, 16'hAAAA, 5'd0);
        push_beat(OP_UPD_CAP, 0, 0, 0, 0, 16'h5555, 5'd31);
        push_beat(OP_ADD_EXT, 16'h0100, 0, 16'hFFFF, 16'hFFFF, 0, 0);
        push_beat(OP_ADD_EXT, 16'h0200, 0, 16'h0001, 16'h0FFC, 0, 0);
        push_beat(OP_ADD_EXT, 16'hFFFF, 0, 16'h0001, 0, 0, 0);
        push_beat(OP_RSVD6, 16'hFFFF, '1, '1, '1, '1, '1);
        push_beat(OP_RSVD7, 0, 0, 0, 0, 0, 0);
        push_beat(OP_READ, 16'h0034, 0, 0, 0, 0, 0);
        push_beat(OP_READ, 16'h0100, 0, 0, 0, 0, 0);
        run_random(130);
        wait_idle();

        // small space: extended adds and other beats at offsets of 256 and above must fail
        set_all(0, 16'h0000, 16'h0000, 8'h00, 8'h00, 0, 1);
        run_random(150);
        wait_idle();

        set_all(1, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 1, 0);
        run_random(150);
        wait_idle();

        calm = 1;
        set_all(1'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 1, 1);
        run_random(150);
        wait_idle();
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #50000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
